// ===== hdl/lwhs_pkg.sv =====
// shared types and constants for the latency weighted home select block
// no dependencies; compiled before every other file of the block
`default_nettype none

package lwhs_pkg;

  // field widths
  localparam int WEIGHT_W = 32;
  localparam int TIME_W   = 16;
  localparam int INDEX_W  = 3;
  localparam int COUNT_W  = 4;
  localparam int FACTOR_W = 16;
  localparam int PROD_W   = WEIGHT_W + FACTOR_W;

  // default table depth
  localparam int DEF_MAX_HOMES = 8;

  // reset value of the home count register
  localparam logic [COUNT_W-1:0] HOME_COUNT_RESET = COUNT_W'(1);

  // q0.16 factors
  localparam logic [FACTOR_W-1:0] ALPHA_Q16   = 16'd46959;
  localparam logic [FACTOR_W-1:0] BETA_Q16    = 16'd18577;
  localparam logic [FACTOR_W-1:0] PASSIVE_Q16 = 16'd58982;

  // factor fed to the shared multiplier
  typedef enum logic [1:0] {
    FAC_BETA,
    FAC_ALPHA,
    FAC_PASSIVE
  } factor_sel_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL,
    ST_UPD,
    ST_RD,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/lwhs_if.sv =====
// request channels of the latency weighted home select block
// depends on lwhs_pkg for field widths
`default_nettype none

interface lwhs_in_if import lwhs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [INDEX_W-1:0] home_index;
  logic [TIME_W-1:0]  connect_time;

  modport source (output valid, output home_index, output connect_time, input ready);
  modport sink (input valid, input home_index, input connect_time, output ready);
endinterface

interface lwhs_out_if import lwhs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  best_home;
  logic [WEIGHT_W-1:0] min_weight;

  modport source (output valid, output best_home, output min_weight, input ready);
  modport sink (input valid, input best_home, input min_weight, output ready);
endinterface

interface lwhs_cfg_if import lwhs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] home_count;

  modport source (output valid, output home_count, input ready);
  modport sink (input valid, input home_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/latency_weighted_home_select_top.sv =====
// top level of the latency weighted home select block
// depends on lwhs_pkg, the channel interfaces in lwhs_if and lwhs_mul_unit
//
// usage
//   cfg_ch  : write of home_count (homes in use), taken every cycle; write it
//             only while the block is idle. a count above MAX_HOMES acts as
//             MAX_HOMES, a count of zero freezes all weights
//   in_ch   : one request = home_index plus connect_time in whole seconds
//   out_ch  : one result per request: best_home and its q16.16 min_weight
// sequencing
//   every home in use (at least one) goes through read, multiply and update
//   on the single shared multiplier. one request is worked on at a time;
//   in_ch.ready is high only while the sequencer idles, so a new request is
//   taken only after the result of the previous one has gone into the
//   output register
// reset
//   rst_n is synchronous, active low. all weights read as zero after reset
//   (valid bit per entry), home_count returns to 1, no result is pending
// stall
//   the result sits in an output register; a new request is taken while it
//   waits, and the next result is held back until out_ch drains the first
`default_nettype none

module latency_weighted_home_select_top import lwhs_pkg::*; #(
  parameter int MAX_HOMES = DEF_MAX_HOMES
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  lwhs_in_if.sink       in_ch,
  lwhs_out_if.source    out_ch,
  lwhs_cfg_if.sink      cfg_ch
);

  localparam int IW     = $clog2(MAX_HOMES);
  localparam int CW     = $clog2(MAX_HOMES + 1);
  localparam int CNTW   = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int CMPW   = (IW > INDEX_W) ? IW : INDEX_W;

  // configuration
  logic [COUNT_W-1:0] home_count_r;

  // sequencer
  state_t state_r, state_nxt;
  logic [IW-1:0] idx_r;

  // captured request
  logic [INDEX_W-1:0] req_index_r;
  logic [TIME_W-1:0]  req_time_r;

  // weight store with a valid bit per entry, zero when not valid
  logic [WEIGHT_W-1:0]  mem [MAX_HOMES];
  logic [MAX_HOMES-1:0] wvalid_r;
  logic [WEIGHT_W-1:0]  rd_data_r;
  logic                 rd_valid_r;
  logic [WEIGHT_W-1:0]  cur_w;

  // running argmin
  logic [IW-1:0]       best_idx_r;
  logic [WEIGHT_W-1:0] best_w_r;

  // output register
  logic                out_valid_r;
  logic [INDEX_W-1:0]  out_home_r;
  logic [WEIGHT_W-1:0] out_weight_r;

  // control
  logic        in_take;
  logic        mul_en;
  factor_sel_t fac_sel;
  logic [WEIGHT_W-1:0] mul_a;
  logic        load_tb;
  logic        blend;
  logic        upd_step;
  logic        wr_en;
  logic        out_load;
  logic [WEIGHT_W-1:0] new_w;

  // active home count and last index of the scan
  logic [CNTW-1:0] cnt_ext;
  logic [CNTW-1:0] n_eff;
  logic [CNTW-1:0] n_last;
  logic            none_active;
  logic            is_last;
  logic            is_target;

  assign cnt_ext     = CNTW'(home_count_r);
  assign n_eff       = (cnt_ext > CNTW'(MAX_HOMES)) ? CNTW'(MAX_HOMES) : cnt_ext;
  assign none_active = (n_eff == '0);
  assign n_last      = none_active ? '0 : n_eff - CNTW'(1);
  assign is_last     = (CNTW'(idx_r) == n_last);
  assign is_target   = !none_active && (CMPW'(idx_r) == CMPW'(req_index_r));

  assign cur_w = rd_valid_r ? rd_data_r : '0;

  // channel handshakes
  assign in_ch.ready        = (state_r == ST_IDLE);
  assign in_take            = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.best_home   = out_home_r;
  assign out_ch.min_weight  = out_weight_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = is_last ? ST_FIN : ST_RD;
      ST_RD:   state_nxt = ST_MUL;
      ST_FIN:  if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mul_en   = 1'b0;
    fac_sel  = FAC_PASSIVE;
    mul_a    = cur_w;
    load_tb  = 1'b0;
    blend    = 1'b0;
    upd_step = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        // time * beta goes through the multiplier first
        mul_en  = 1'b1;
        fac_sel = FAC_BETA;
        mul_a   = WEIGHT_W'(req_time_r);
      end
      ST_MUL: begin
        mul_en  = 1'b1;
        fac_sel = is_target ? FAC_ALPHA : FAC_PASSIVE;
        load_tb = (idx_r == '0);
      end
      ST_UPD: begin
        blend    = is_target;
        upd_step = 1'b1;
      end
      ST_FIN: begin
        out_load = !out_valid_r || out_ch.ready;
      end
      default: begin
      end
    endcase
  end

  lwhs_mul_unit u_mul (
    .clk     (clk),
    .mul_en  (mul_en),
    .fac_sel (fac_sel),
    .mul_a   (mul_a),
    .load_tb (load_tb),
    .blend   (blend),
    .result  (new_w)
  );

  // with no homes in use the weight is only read, never changed
  logic [WEIGHT_W-1:0] upd_w;
  assign upd_w = none_active ? cur_w : new_w;
  assign wr_en = upd_step && !none_active;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      home_count_r <= HOME_COUNT_RESET;
      wvalid_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        home_count_r <= cfg_ch.home_count;
      end
      if (wr_en) begin
        wvalid_r[idx_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // weight memory, registered read at the scan index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_r] <= upd_w;
    end
    rd_data_r  <= mem[idx_r];
    rd_valid_r <= wvalid_r[idx_r] && rst_n;
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_index_r <= in_ch.home_index;
      req_time_r  <= in_ch.connect_time;
      idx_r       <= '0;
    end
    if (upd_step) begin
      // strict less-than keeps the lowest index on ties
      if (idx_r == '0 || upd_w < best_w_r) begin
        best_w_r   <= upd_w;
        best_idx_r <= idx_r;
      end
      if (!is_last) begin
        idx_r <= idx_r + IW'(1);
      end
    end
    if (out_load) begin
      out_home_r   <= INDEX_W'(best_idx_r);
      out_weight_r <= best_w_r;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lwhs_mul_unit.sv =====
// shared multiply unit: weight times a q0.16 factor, registered,
// followed by the truncating shift and the saturating blend add; uses lwhs_pkg
`default_nettype none

module lwhs_mul_unit import lwhs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                mul_en,
  input  wire factor_sel_t         fac_sel,
  input  wire logic [WEIGHT_W-1:0] mul_a,
  input  wire logic                load_tb,
  input  wire logic                blend,
  output logic      [WEIGHT_W-1:0] result
);

  logic [FACTOR_W-1:0] fac;
  logic [PROD_W-1:0]   prod_r;
  logic [WEIGHT_W-1:0] tb_r;
  logic [WEIGHT_W-1:0] kept;
  logic [WEIGHT_W:0]   sum;

  always_comb begin
    unique case (fac_sel)
      FAC_BETA:    fac = BETA_Q16;
      FAC_ALPHA:   fac = ALPHA_Q16;
      FAC_PASSIVE: fac = PASSIVE_Q16;
      default:     fac = PASSIVE_Q16;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(fac);
    end
    // time * beta fits in 31 bits, so the low word holds it whole
    if (load_tb) begin
      tb_r <= prod_r[WEIGHT_W-1:0];
    end
  end

  assign kept = prod_r[PROD_W-1:FACTOR_W];
  assign sum  = {1'b0, kept} + {1'b0, tb_r};

  always_comb begin
    if (!blend) begin
      result = kept;
    end else if (sum[WEIGHT_W]) begin
      result = '1;
    end else begin
      result = sum[WEIGHT_W-1:0];
    end
  end

endmodule

`default_nettype wire
